>>> design/jtl_pkg.sv
// jtl_pkg: shared types, token codes and character constants of the json token lexer
package jtl_pkg;

    // result field widths
    localparam int KIND_BITS      = 4;
    localparam int ERR_BITS       = 3;
    localparam int OFF_FIELD_BITS = 32;
    localparam int POS_FIELD_BITS = 16;

    localparam logic [OFF_FIELD_BITS-1:0] OFF_FIELD_MAX = '1;
    localparam logic [POS_FIELD_BITS-1:0] POS_FIELD_MAX = '1;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACKET = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACKET = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_COMMA    = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_COLON    = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER   = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_STRING   = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_TRUE     = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_FALSE    = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_NULL     = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 4'd11;
    localparam logic [KIND_BITS-1:0] KIND_END      = 4'd12;

    // error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_BAD_CHAR    = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_NO_INT      = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_NO_FRAC     = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_NO_EXP      = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_OPEN_STRING = 3'd5;
    localparam logic [ERR_BITS-1:0] ERR_BAD_KEYWORD = 3'd6;

    // keyword selects
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // characters
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_E      = 8'h45;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_UP_L      = 8'h4C;
    localparam logic [7:0] CH_UP_N      = 8'h4E;
    localparam logic [7:0] CH_UP_R      = 8'h52;
    localparam logic [7:0] CH_UP_S      = 8'h53;
    localparam logic [7:0] CH_UP_T      = 8'h54;
    localparam logic [7:0] CH_UP_U      = 8'h55;
    localparam logic [7:0] CASE_FOLD    = 8'hDF;

    // lexer modes
    typedef enum logic [3:0] {
        MODE_START,
        MODE_NSIGN,
        MODE_NZERO,
        MODE_NINT,
        MODE_NDOT,
        MODE_NFRAC,
        MODE_NE,
        MODE_NESIGN,
        MODE_NEXP,
        MODE_STR,
        MODE_STRESC,
        MODE_KEYW,
        MODE_HALT
    } t_mode;

    // one input byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_item;

    // one result
    typedef struct packed {
        logic [KIND_BITS-1:0]      token_kind;
        logic [ERR_BITS-1:0]       error_code;
        logic [OFF_FIELD_BITS-1:0] token_offset;
        logic [OFF_FIELD_BITS-1:0] token_length;
        logic [POS_FIELD_BITS-1:0] line_number;
        logic [POS_FIELD_BITS-1:0] column_number;
        logic                      last_of_run;
    } t_result;

    // up to two results written per byte
    typedef struct packed {
        logic    first_v;
        logic    second_v;
        t_result first;
        t_result second;
    } t_push;

    // upper-case keyword letter at a position, zero past the end
    function automatic logic [7:0] kw_letter(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (sel)
            KW_TRUE: begin
                unique case (pos)
                    3'd0: ch = CH_UP_T;
                    3'd1: ch = CH_UP_R;
                    3'd2: ch = CH_UP_U;
                    3'd3: ch = CH_UP_E;
                    default: ch = CH_NUL;
                endcase
            end
            KW_FALSE: begin
                unique case (pos)
                    3'd0: ch = CH_UP_F;
                    3'd1: ch = CH_UP_A;
                    3'd2: ch = CH_UP_L;
                    3'd3: ch = CH_UP_S;
                    3'd4: ch = CH_UP_E;
                    default: ch = CH_NUL;
                endcase
            end
            KW_NULL: begin
                unique case (pos)
                    3'd0: ch = CH_UP_N;
                    3'd1: ch = CH_UP_U;
                    3'd2: ch = CH_UP_L;
                    3'd3: ch = CH_UP_L;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // keyword length, zero for the unused select
    function automatic logic [2:0] kw_length(input logic [1:0] sel);
        logic [2:0] len;
        unique case (sel)
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_NULL:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    // token kind of a keyword
    function automatic logic [KIND_BITS-1:0] kw_kind(input logic [1:0] sel);
        logic [KIND_BITS-1:0] kind;
        unique case (sel)
            KW_TRUE:  kind = KIND_TRUE;
            KW_FALSE: kind = KIND_FALSE;
            default:  kind = KIND_NULL;
        endcase
        return kind;
    endfunction

endpackage

>>> design/jtl_if.sv
// jtl_in_if and jtl_out_if: byte request channel and token result channel
interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface jtl_out_if;
    logic                               valid;
    logic                               ready;
    logic [jtl_pkg::KIND_BITS-1:0]      token_kind;
    logic [jtl_pkg::ERR_BITS-1:0]       error_code;
    logic [jtl_pkg::OFF_FIELD_BITS-1:0] token_offset;
    logic [jtl_pkg::OFF_FIELD_BITS-1:0] token_length;
    logic [jtl_pkg::POS_FIELD_BITS-1:0] line_number;
    logic [jtl_pkg::POS_FIELD_BITS-1:0] column_number;
    logic                               last_of_run;

    modport source (output valid, output token_kind, output error_code, output token_offset,
                    output token_length, output line_number, output column_number,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input error_code, input token_offset,
                    input token_length, input line_number, input column_number,
                    input last_of_run, output ready);
endinterface

>>> design/jtl_core.sv
// jtl_core: lexer state machine, position counters and result formation for one byte
module jtl_core #(
    parameter int OFFSET_BITS   = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  jtl_pkg::t_item i_item,
    output jtl_pkg::t_push o_push
);

    localparam int OW = (OFFSET_BITS > jtl_pkg::OFF_FIELD_BITS) ?
                        OFFSET_BITS : jtl_pkg::OFF_FIELD_BITS;
    localparam int PW = (POSITION_BITS > jtl_pkg::POS_FIELD_BITS) ?
                        POSITION_BITS : jtl_pkg::POS_FIELD_BITS;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    function automatic logic [OFFSET_BITS-1:0] off_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [jtl_pkg::OFF_FIELD_BITS-1:0] off_clip(
        input logic [OFFSET_BITS-1:0] v);
        logic [OW-1:0] w;
        w = OW'(v);
        return (w > OW'(jtl_pkg::OFF_FIELD_MAX)) ? jtl_pkg::OFF_FIELD_MAX :
               w[jtl_pkg::OFF_FIELD_BITS-1:0];
    endfunction

    function automatic logic [jtl_pkg::POS_FIELD_BITS-1:0] pos_clip(
        input logic [POSITION_BITS-1:0] v);
        logic [PW-1:0] w;
        w = PW'(v);
        return (w > PW'(jtl_pkg::POS_FIELD_MAX)) ? jtl_pkg::POS_FIELD_MAX :
               w[jtl_pkg::POS_FIELD_BITS-1:0];
    endfunction

    // state
    jtl_pkg::t_mode           r_mode, n_mode;
    logic [1:0]               r_kw_sel, n_kw_sel;
    logic [2:0]               r_kw_pos, n_kw_pos;
    logic [OFFSET_BITS-1:0]   r_byte_off, n_byte_off;
    logic [OFFSET_BITS-1:0]   r_tok_start, n_tok_start;
    logic [POSITION_BITS-1:0] r_cur_line, n_cur_line;
    logic [POSITION_BITS-1:0] r_cur_col, n_cur_col;
    logic [POSITION_BITS-1:0] r_tok_line, n_tok_line;
    logic [POSITION_BITS-1:0] r_tok_col, n_tok_col;

    // decode
    logic [7:0]                      b, b_up;
    logic                            is_end, is_dig, is_expo, is_ws, is_lf;
    logic                            is_punct, is_kw_first, marks_start;
    logic [jtl_pkg::KIND_BITS-1:0]   punct_kind;
    logic                            num_mode, accepting, num_ok, dispatch;
    jtl_pkg::t_mode                  num_nxt;
    logic [jtl_pkg::ERR_BITS-1:0]    num_err;
    logic [2:0]                      kw_len;
    logic                            kw_hit, kw_done;
    logic [OFFSET_BITS-1:0]          tok_len;

    // results
    logic                            a_v, b_v;
    logic [jtl_pkg::KIND_BITS-1:0]   a_kind, b_kind;
    logic [jtl_pkg::ERR_BITS-1:0]    a_err, b_err;
    logic [OFFSET_BITS-1:0]          a_len, b_len;
    jtl_pkg::t_result                res_a, res_b;

    // byte classification and per-mode decisions
    always_comb begin
        b           = i_item.text_byte;
        b_up        = b & jtl_pkg::CASE_FOLD;
        is_end      = i_item.end_of_input || (b == jtl_pkg::CH_NUL);
        is_dig      = (b >= jtl_pkg::CH_ZERO) && (b <= jtl_pkg::CH_NINE);
        is_expo     = (b_up == jtl_pkg::CH_UP_E);
        is_lf       = (b == jtl_pkg::CH_LF);
        is_ws       = (b == jtl_pkg::CH_SPACE) || (b == jtl_pkg::CH_TAB) ||
                      (b == jtl_pkg::CH_CR) || (b == jtl_pkg::CH_FF) ||
                      (b == jtl_pkg::CH_VT);
        is_kw_first = (b_up == jtl_pkg::CH_UP_T) || (b_up == jtl_pkg::CH_UP_F) ||
                      (b_up == jtl_pkg::CH_UP_N);

        is_punct   = 1'b1;
        punct_kind = jtl_pkg::KIND_LBRACE;
        priority if (b == jtl_pkg::CH_LBRACE)   punct_kind = jtl_pkg::KIND_LBRACE;
        else if (b == jtl_pkg::CH_RBRACE)       punct_kind = jtl_pkg::KIND_RBRACE;
        else if (b == jtl_pkg::CH_LBRACKET)     punct_kind = jtl_pkg::KIND_LBRACKET;
        else if (b == jtl_pkg::CH_RBRACKET)     punct_kind = jtl_pkg::KIND_RBRACKET;
        else if (b == jtl_pkg::CH_COMMA)        punct_kind = jtl_pkg::KIND_COMMA;
        else if (b == jtl_pkg::CH_COLON)        punct_kind = jtl_pkg::KIND_COLON;
        else                                    is_punct   = 1'b0;

        // number grammar step
        num_nxt = jtl_pkg::MODE_HALT;
        num_err = jtl_pkg::ERR_NONE;
        unique case (r_mode)
            jtl_pkg::MODE_NSIGN: begin
                num_err = jtl_pkg::ERR_NO_INT;
                if (b == jtl_pkg::CH_ZERO) num_nxt = jtl_pkg::MODE_NZERO;
                else if (is_dig)           num_nxt = jtl_pkg::MODE_NINT;
            end
            jtl_pkg::MODE_NZERO: begin
                if (b == jtl_pkg::CH_DOT) num_nxt = jtl_pkg::MODE_NDOT;
                else if (is_expo)         num_nxt = jtl_pkg::MODE_NE;
            end
            jtl_pkg::MODE_NINT: begin
                if (is_dig)                    num_nxt = jtl_pkg::MODE_NINT;
                else if (b == jtl_pkg::CH_DOT) num_nxt = jtl_pkg::MODE_NDOT;
                else if (is_expo)              num_nxt = jtl_pkg::MODE_NE;
            end
            jtl_pkg::MODE_NDOT: begin
                num_err = jtl_pkg::ERR_NO_FRAC;
                if (is_dig) num_nxt = jtl_pkg::MODE_NFRAC;
            end
            jtl_pkg::MODE_NFRAC: begin
                if (is_dig)       num_nxt = jtl_pkg::MODE_NFRAC;
                else if (is_expo) num_nxt = jtl_pkg::MODE_NE;
            end
            jtl_pkg::MODE_NE: begin
                num_err = jtl_pkg::ERR_NO_EXP;
                if ((b == jtl_pkg::CH_PLUS) || (b == jtl_pkg::CH_MINUS))
                    num_nxt = jtl_pkg::MODE_NESIGN;
                else if (is_dig)
                    num_nxt = jtl_pkg::MODE_NEXP;
            end
            jtl_pkg::MODE_NESIGN: begin
                num_err = jtl_pkg::ERR_NO_EXP;
                if (is_dig) num_nxt = jtl_pkg::MODE_NEXP;
            end
            jtl_pkg::MODE_NEXP: begin
                if (is_dig) num_nxt = jtl_pkg::MODE_NEXP;
            end
            default: num_nxt = jtl_pkg::MODE_HALT;
        endcase
        num_ok    = (num_nxt != jtl_pkg::MODE_HALT);
        num_mode  = (r_mode >= jtl_pkg::MODE_NSIGN) && (r_mode <= jtl_pkg::MODE_NEXP);
        accepting = (r_mode == jtl_pkg::MODE_NZERO) || (r_mode == jtl_pkg::MODE_NINT) ||
                    (r_mode == jtl_pkg::MODE_NFRAC) || (r_mode == jtl_pkg::MODE_NEXP);

        // keyword letter match
        kw_len  = jtl_pkg::kw_length(r_kw_sel);
        kw_hit  = (r_kw_pos < kw_len) && (b_up == jtl_pkg::kw_letter(r_kw_sel, r_kw_pos));
        kw_done = (3'(r_kw_pos + 3'd1) == kw_len);

        dispatch    = !is_end && ((r_mode == jtl_pkg::MODE_START) ||
                                  (num_mode && !num_ok && accepting));
        marks_start = dispatch && ((b == jtl_pkg::CH_MINUS) || is_dig || is_kw_first);
        tok_len     = (r_byte_off >= r_tok_start) ? r_byte_off - r_tok_start : '0;
    end

    // next lexer mode and keyword tracking
    always_comb begin
        n_mode   = r_mode;
        n_kw_sel = r_kw_sel;
        n_kw_pos = r_kw_pos;
        if (i_vld) begin
            if (is_end) begin
                n_mode   = jtl_pkg::MODE_START;
                n_kw_sel = 2'd0;
                n_kw_pos = 3'd0;
            end else begin
                unique case (r_mode)
                    jtl_pkg::MODE_NSIGN, jtl_pkg::MODE_NZERO, jtl_pkg::MODE_NINT,
                    jtl_pkg::MODE_NDOT, jtl_pkg::MODE_NFRAC, jtl_pkg::MODE_NE,
                    jtl_pkg::MODE_NESIGN, jtl_pkg::MODE_NEXP: begin
                        if (num_ok)         n_mode = num_nxt;
                        else if (accepting) n_mode = jtl_pkg::MODE_START;
                        else                n_mode = jtl_pkg::MODE_HALT;
                    end
                    jtl_pkg::MODE_STR: begin
                        if (b == jtl_pkg::CH_QUOTE)          n_mode = jtl_pkg::MODE_START;
                        else if (b == jtl_pkg::CH_BACKSLASH) n_mode = jtl_pkg::MODE_STRESC;
                    end
                    jtl_pkg::MODE_STRESC: n_mode = jtl_pkg::MODE_STR;
                    jtl_pkg::MODE_KEYW: begin
                        if (kw_hit) begin
                            n_kw_pos = 3'(r_kw_pos + 3'd1);
                            if (kw_done) begin
                                n_mode   = jtl_pkg::MODE_START;
                                n_kw_pos = 3'd0;
                            end
                        end else begin
                            n_mode = jtl_pkg::MODE_HALT;
                        end
                    end
                    default: n_mode = r_mode;
                endcase

                // byte at a token boundary
                if (dispatch) begin
                    priority if (b == jtl_pkg::CH_MINUS) begin
                        n_mode = jtl_pkg::MODE_NSIGN;
                    end else if (b == jtl_pkg::CH_ZERO) begin
                        n_mode = jtl_pkg::MODE_NZERO;
                    end else if (is_dig) begin
                        n_mode = jtl_pkg::MODE_NINT;
                    end else if (b == jtl_pkg::CH_QUOTE) begin
                        n_mode = jtl_pkg::MODE_STR;
                    end else if (is_kw_first) begin
                        n_mode   = jtl_pkg::MODE_KEYW;
                        n_kw_pos = 3'd1;
                        if (b_up == jtl_pkg::CH_UP_T)      n_kw_sel = jtl_pkg::KW_TRUE;
                        else if (b_up == jtl_pkg::CH_UP_F) n_kw_sel = jtl_pkg::KW_FALSE;
                        else                               n_kw_sel = jtl_pkg::KW_NULL;
                    end else if (is_punct || is_ws || is_lf) begin
                        n_mode = jtl_pkg::MODE_START;
                    end else begin
                        n_mode = jtl_pkg::MODE_HALT;
                    end
                end
            end
        end
    end

    // offsets, positions and token start marks
    always_comb begin
        n_byte_off  = r_byte_off;
        n_tok_start = r_tok_start;
        n_cur_line  = r_cur_line;
        n_cur_col   = r_cur_col;
        n_tok_line  = r_tok_line;
        n_tok_col   = r_tok_col;
        if (i_vld) begin
            if (is_end) begin
                n_byte_off  = '0;
                n_tok_start = '0;
                n_cur_line  = POS_ONE;
                n_cur_col   = POS_ONE;
                n_tok_line  = POS_ONE;
                n_tok_col   = POS_ONE;
            end else begin
                if (marks_start) begin
                    n_tok_start = r_byte_off;
                    n_tok_line  = r_cur_line;
                    n_tok_col   = r_cur_col;
                end else if (dispatch && (b == jtl_pkg::CH_QUOTE)) begin
                    // string content starts after the quote
                    n_tok_start = off_inc(r_byte_off);
                    n_tok_line  = r_cur_line;
                    n_tok_col   = pos_inc(r_cur_col);
                end
                n_byte_off = off_inc(r_byte_off);
                if (dispatch && is_lf) begin
                    n_cur_line = pos_inc(r_cur_line);
                    n_cur_col  = POS_ONE;
                end else begin
                    n_cur_col  = pos_inc(r_cur_col);
                end
            end
        end
    end

    // results: a closes the pending token, b comes from the byte itself
    always_comb begin
        a_v    = 1'b0;
        a_kind = jtl_pkg::KIND_ERROR;
        a_err  = jtl_pkg::ERR_NONE;
        a_len  = tok_len;
        b_v    = 1'b0;
        b_kind = jtl_pkg::KIND_END;
        b_err  = jtl_pkg::ERR_NONE;
        b_len  = '0;
        if (i_vld) begin
            if (is_end) begin
                b_v = 1'b1;
                unique case (r_mode)
                    jtl_pkg::MODE_NSIGN: begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_NO_INT;
                    end
                    jtl_pkg::MODE_NDOT: begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_NO_FRAC;
                    end
                    jtl_pkg::MODE_NE, jtl_pkg::MODE_NESIGN: begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_NO_EXP;
                    end
                    jtl_pkg::MODE_STR, jtl_pkg::MODE_STRESC: begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_OPEN_STRING;
                    end
                    jtl_pkg::MODE_KEYW: begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_BAD_KEYWORD;
                        a_len = '0;
                    end
                    jtl_pkg::MODE_NZERO, jtl_pkg::MODE_NINT, jtl_pkg::MODE_NFRAC,
                    jtl_pkg::MODE_NEXP: begin
                        a_v    = 1'b1;
                        a_kind = jtl_pkg::KIND_NUMBER;
                    end
                    default: a_v = 1'b0;
                endcase
            end else begin
                if (num_mode && !num_ok) begin
                    a_v = 1'b1;
                    if (accepting) a_kind = jtl_pkg::KIND_NUMBER;
                    else           a_err  = num_err;
                end else if ((r_mode == jtl_pkg::MODE_STR) && (b == jtl_pkg::CH_QUOTE)) begin
                    a_v    = 1'b1;
                    a_kind = jtl_pkg::KIND_STRING;
                end else if (r_mode == jtl_pkg::MODE_KEYW) begin
                    if (!kw_hit) begin
                        a_v   = 1'b1;
                        a_err = jtl_pkg::ERR_BAD_KEYWORD;
                        a_len = '0;
                    end else if (kw_done) begin
                        a_v    = 1'b1;
                        a_kind = jtl_pkg::kw_kind(r_kw_sel);
                        a_len  = OFFSET_BITS'(kw_len);
                    end
                end
                if (dispatch) begin
                    if (is_punct) begin
                        b_v    = 1'b1;
                        b_kind = punct_kind;
                        b_len  = OFFSET_BITS'(1);
                    end else if (!(is_ws || is_lf || marks_start ||
                                   (b == jtl_pkg::CH_QUOTE))) begin
                        b_v    = 1'b1;
                        b_kind = jtl_pkg::KIND_ERROR;
                        b_err  = jtl_pkg::ERR_BAD_CHAR;
                    end
                end
            end
        end

        res_a.token_kind    = a_kind;
        res_a.error_code    = a_err;
        res_a.token_offset  = off_clip(r_tok_start);
        res_a.token_length  = off_clip(a_len);
        res_a.line_number   = pos_clip(r_tok_line);
        res_a.column_number = pos_clip(r_tok_col);
        res_a.last_of_run   = !b_v;

        res_b.token_kind    = b_kind;
        res_b.error_code    = b_err;
        res_b.token_offset  = off_clip(r_byte_off);
        res_b.token_length  = off_clip(b_len);
        res_b.line_number   = pos_clip(r_cur_line);
        res_b.column_number = pos_clip(r_cur_col);
        res_b.last_of_run   = 1'b1;

        o_push.first_v  = a_v || b_v;
        o_push.second_v = a_v && b_v;
        o_push.first    = a_v ? res_a : res_b;
        o_push.second   = res_b;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= jtl_pkg::MODE_START;
            r_kw_sel    <= 2'd0;
            r_kw_pos    <= 3'd0;
            r_byte_off  <= '0;
            r_tok_start <= '0;
            r_cur_line  <= POS_ONE;
            r_cur_col   <= POS_ONE;
            r_tok_line  <= POS_ONE;
            r_tok_col   <= POS_ONE;
        end else begin
            r_mode      <= n_mode;
            r_kw_sel    <= n_kw_sel;
            r_kw_pos    <= n_kw_pos;
            r_byte_off  <= n_byte_off;
            r_tok_start <= n_tok_start;
            r_cur_line  <= n_cur_line;
            r_cur_col   <= n_cur_col;
            r_tok_line  <= n_tok_line;
            r_tok_col   <= n_tok_col;
        end
    end

    // end marker returns the lexer to its reset state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && is_end) |=> (r_mode == jtl_pkg::MODE_START) && (r_byte_off == '0) &&
                              (r_cur_line == POS_ONE) && (r_cur_col == POS_ONE))
        else $error("lexer state not cleared after end marker");

    // halted lexer stays silent on ordinary bytes
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == jtl_pkg::MODE_HALT) && i_vld && !is_end) |-> !o_push.first_v)
        else $error("result produced while halted");

    // an error on an ordinary byte halts the lexer
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && !is_end && o_push.first_v &&
         (o_push.first.token_kind == jtl_pkg::KIND_ERROR)) |=>
        (r_mode == jtl_pkg::MODE_HALT))
        else $error("lexer not halted after error");

endmodule

>>> design/jtl_outq.sv
// jtl_outq: result queue taking up to two results per cycle and giving one per request
module jtl_outq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  jtl_pkg::t_push                      i_push,
    output logic [jtl_pkg::QCNT_BITS-1:0]       o_count,
    jtl_out_if.source                           o_out
);

    jtl_pkg::t_result                 r_mem [jtl_pkg::QUEUE_DEPTH];
    logic [jtl_pkg::QPTR_BITS-1:0]    r_wr, r_rd;
    logic [jtl_pkg::QCNT_BITS-1:0]    r_cnt, n_cnt;
    logic [jtl_pkg::QCNT_BITS-1:0]    push_n;
    logic                             pop;
    jtl_pkg::t_result                 head;

    // occupancy bookkeeping
    always_comb begin
        pop    = o_out.valid && o_out.ready;
        push_n = jtl_pkg::QCNT_BITS'(i_push.first_v) + jtl_pkg::QCNT_BITS'(i_push.second_v);
        n_cnt  = r_cnt + push_n - jtl_pkg::QCNT_BITS'(pop);
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.first_v) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.second_v) begin
            r_mem[jtl_pkg::QPTR_BITS'(r_wr + 1'b1)] <= i_push.second;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + jtl_pkg::QPTR_BITS'(push_n);
            r_rd  <= r_rd + jtl_pkg::QPTR_BITS'(pop);
            r_cnt <= n_cnt;
        end
    end

    // head of queue to the port
    assign head                = r_mem[r_rd];
    assign o_count             = r_cnt;
    assign o_out.valid         = (r_cnt != '0);
    assign o_out.token_kind    = head.token_kind;
    assign o_out.error_code    = head.error_code;
    assign o_out.token_offset  = head.token_offset;
    assign o_out.token_length  = head.token_length;
    assign o_out.line_number   = head.line_number;
    assign o_out.column_number = head.column_number;
    assign o_out.last_of_run   = head.last_of_run;

    // queue never holds more than its depth
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= jtl_pkg::QCNT_BITS'(jtl_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // the second slot is only used together with the first
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second_v |-> i_push.first_v)
        else $error("second result written without first");

endmodule

>>> design/json_token_lexer.sv
// json_token_lexer: top level of the byte-serial json tokenizer
//
// Usage: i_in carries one document byte per request (text_byte, with
// end_of_input marking the end of a document; a zero byte also ends it).
// o_out carries tokens: kind, error code, offset, length, line and column,
// with last_of_run set on the final token caused by a byte. A byte gives
// zero, one or two tokens; the end marker gives an end token, preceded by a
// pending number or an error for an unfinished token.
// A byte passes the input register, then the lexer step into the queue.
// Throughput: one byte per cycle while i_in.ready is high. The queue holds
// 8 results; i_in.ready is low while queued results plus those of the byte
// in the input register could leave no room for two more, so ready drops
// only when the receiver stalls or bytes yield two tokens faster than they
// are taken.
// Reset (synchronous, active low) clears the lexer to the start of a
// document at line 1, column 1 and empties the queue. A stalled receiver
// holds the head token steady; later results wait in the queue.
module json_token_lexer #(
    parameter int OFFSET_BITS   = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jtl_in_if.sink    i_in,
    jtl_out_if.source o_out
);

    localparam int CW = jtl_pkg::QCNT_BITS + 1;
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(jtl_pkg::QUEUE_DEPTH - 2);

    logic                              r_in_vld;
    jtl_pkg::t_item                    r_in_item;
    logic                              accept;
    logic [jtl_pkg::QCNT_BITS-1:0]     q_count;
    logic [CW-1:0]                     committed;
    jtl_pkg::t_push                    push;

    // accept only when every result in flight still fits
    always_comb begin
        committed  = CW'(q_count) + (r_in_vld ? CW'(2) : CW'(0));
        i_in.ready = (committed <= ROOM_LIMIT);
        accept     = i_in.valid && i_in.ready;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item.text_byte    <= i_in.text_byte;
            r_in_item.end_of_input <= i_in.end_of_input;
        end
    end

    // lexer step
    jtl_core #(
        .OFFSET_BITS   (OFFSET_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    // result queue
    jtl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_out   (o_out)
    );

endmodule

>>> tb/sv/jtl_token_checker.sv
// jtl_token_checker: token predictor and result comparison for the json token lexer
`timescale 1ns / 100ps
module jtl_token_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jtl_in_if    i_byte_ch,
    jtl_out_if   i_tok_ch,
    output int   o_fail_count,
    output int   o_expect_count
);
    import jtl_pkg::*;

    // predicted lexer state
    t_mode                     lex_mode;
    logic [1:0]                kw_sel;
    logic [2:0]                kw_idx;
    logic [OFF_FIELD_BITS-1:0] doc_offset;
    logic [OFF_FIELD_BITS-1:0] tok_offset;
    logic [POS_FIELD_BITS-1:0] cur_line;
    logic [POS_FIELD_BITS-1:0] cur_col;
    logic [POS_FIELD_BITS-1:0] tok_line;
    logic [POS_FIELD_BITS-1:0] tok_col;

    // tokens of the current request, then the ones still owed by the block
    t_result step_tok [2];
    int      step_n;
    t_result tokens_due [$];
    int      mismatch_total;

    function automatic logic [OFF_FIELD_BITS-1:0] sat_off(input logic [OFF_FIELD_BITS-1:0] v);
        return (v == OFF_FIELD_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POS_FIELD_BITS-1:0] sat_pos(input logic [POS_FIELD_BITS-1:0] v);
        return (v == POS_FIELD_MAX) ? v : v + 1'b1;
    endfunction

    function automatic string keyword_spelling(input logic [1:0] sel);
        case (sel)
            KW_TRUE:  return "TRUE";
            KW_FALSE: return "FALSE";
            default:  return "NULL";
        endcase
    endfunction

    function automatic void clear_lexer();
        lex_mode   = MODE_START;
        kw_sel     = KW_TRUE;
        kw_idx     = '0;
        doc_offset = '0;
        tok_offset = '0;
        cur_line   = 1;
        cur_col    = 1;
        tok_line   = 1;
        tok_col    = 1;
    endfunction

    function automatic void emit(input logic [KIND_BITS-1:0] kind,
                                 input logic [ERR_BITS-1:0] err,
                                 input logic [OFF_FIELD_BITS-1:0] off,
                                 input logic [OFF_FIELD_BITS-1:0] len,
                                 input logic [POS_FIELD_BITS-1:0] line,
                                 input logic [POS_FIELD_BITS-1:0] col);
        t_result tok;
        tok.token_kind    = kind;
        tok.error_code    = err;
        tok.token_offset  = off;
        tok.token_length  = len;
        tok.line_number   = line;
        tok.column_number = col;
        tok.last_of_run   = 1'b0;
        step_tok[step_n]  = tok;
        step_n++;
    endfunction

    // token that began at the marked start
    function automatic void emit_open(input logic [KIND_BITS-1:0] kind,
                                      input logic [ERR_BITS-1:0] err,
                                      input logic [OFF_FIELD_BITS-1:0] len);
        emit(kind, err, tok_offset, len, tok_line, tok_col);
    endfunction

    // one-byte punctuator at the current position
    function automatic void emit_here(input logic [KIND_BITS-1:0] kind);
        emit(kind, ERR_NONE, doc_offset, 1, cur_line, cur_col);
    endfunction

    function automatic logic [OFF_FIELD_BITS-1:0] open_span();
        return (doc_offset >= tok_offset) ? doc_offset - tok_offset : '0;
    endfunction

    function automatic void mark_start();
        tok_offset = doc_offset;
        tok_line   = cur_line;
        tok_col    = cur_col;
    endfunction

    // advance the predicted lexer by one request and collect its tokens
    function automatic void lex_step(input logic [7:0] b, input logic eoi);
        logic                 fin;
        logic                 digit;
        logic                 expo;
        logic                 accepting;
        logic                 dispatch;
        logic                 newline;
        logic [7:0]           folded;
        logic [ERR_BITS-1:0]  errc;
        logic [KIND_BITS-1:0] kind;
        t_mode                nxt;
        string                word;
        step_n    = 0;
        fin       = eoi || (b == CH_NUL);
        folded    = b & CASE_FOLD;
        digit     = (b >= CH_ZERO) && (b <= CH_NINE);
        expo      = (folded == CH_UP_E);
        accepting = (lex_mode == MODE_NZERO) || (lex_mode == MODE_NINT) ||
                    (lex_mode == MODE_NFRAC) || (lex_mode == MODE_NEXP);
        dispatch  = 1'b0;
        newline   = 1'b0;
        nxt       = MODE_HALT;
        errc      = ERR_NONE;

        if (fin) begin
            // close or fail the open token, then the end token
            case (lex_mode)
                MODE_NSIGN:              emit_open(KIND_ERROR, ERR_NO_INT, open_span());
                MODE_NDOT:               emit_open(KIND_ERROR, ERR_NO_FRAC, open_span());
                MODE_NE, MODE_NESIGN:    emit_open(KIND_ERROR, ERR_NO_EXP, open_span());
                MODE_STR, MODE_STRESC:   emit_open(KIND_ERROR, ERR_OPEN_STRING, open_span());
                MODE_KEYW:               emit_open(KIND_ERROR, ERR_BAD_KEYWORD, '0);
                default: begin
                    if (accepting) emit_open(KIND_NUMBER, ERR_NONE, open_span());
                end
            endcase
            emit(KIND_END, ERR_NONE, doc_offset, '0, cur_line, cur_col);
            clear_lexer();
        end else begin
            // number grammar
            case (lex_mode)
                MODE_NSIGN: begin
                    nxt  = (b == CH_ZERO) ? MODE_NZERO : digit ? MODE_NINT : MODE_HALT;
                    errc = ERR_NO_INT;
                end
                MODE_NZERO: begin
                    nxt = (b == CH_DOT) ? MODE_NDOT : expo ? MODE_NE : MODE_HALT;
                end
                MODE_NINT: begin
                    nxt = digit ? MODE_NINT : (b == CH_DOT) ? MODE_NDOT :
                          expo ? MODE_NE : MODE_HALT;
                end
                MODE_NDOT: begin
                    nxt  = digit ? MODE_NFRAC : MODE_HALT;
                    errc = ERR_NO_FRAC;
                end
                MODE_NFRAC: begin
                    nxt = digit ? MODE_NFRAC : expo ? MODE_NE : MODE_HALT;
                end
                MODE_NE: begin
                    nxt  = (b == CH_PLUS || b == CH_MINUS) ? MODE_NESIGN :
                           digit ? MODE_NEXP : MODE_HALT;
                    errc = ERR_NO_EXP;
                end
                MODE_NESIGN: begin
                    nxt  = digit ? MODE_NEXP : MODE_HALT;
                    errc = ERR_NO_EXP;
                end
                MODE_NEXP: begin
                    nxt = digit ? MODE_NEXP : MODE_HALT;
                end
                default: ;
            endcase

            if (lex_mode >= MODE_NSIGN && lex_mode <= MODE_NEXP) begin
                if (nxt != MODE_HALT) begin
                    lex_mode = nxt;
                end else if (accepting) begin
                    // number ends here, the byte starts something new
                    emit_open(KIND_NUMBER, ERR_NONE, open_span());
                    lex_mode = MODE_START;
                    dispatch = 1'b1;
                end else begin
                    emit_open(KIND_ERROR, errc, open_span());
                    lex_mode = MODE_HALT;
                end
            end else if (lex_mode == MODE_STR) begin
                if (b == CH_QUOTE) begin
                    emit_open(KIND_STRING, ERR_NONE, open_span());
                    lex_mode = MODE_START;
                end else if (b == CH_BACKSLASH) begin
                    lex_mode = MODE_STRESC;
                end
            end else if (lex_mode == MODE_STRESC) begin
                lex_mode = MODE_STR;
            end else if (lex_mode == MODE_KEYW) begin
                // keyword letters, any case
                word = keyword_spelling(kw_sel);
                if (kw_idx < word.len() && folded == word[kw_idx]) begin
                    kw_idx = kw_idx + 1'b1;
                    if (kw_idx == word.len()) begin
                        kind = (kw_sel == KW_TRUE) ? KIND_TRUE :
                               (kw_sel == KW_FALSE) ? KIND_FALSE : KIND_NULL;
                        emit_open(kind, ERR_NONE, word.len());
                        lex_mode = MODE_START;
                        kw_idx   = '0;
                    end
                end else begin
                    emit_open(KIND_ERROR, ERR_BAD_KEYWORD, '0);
                    lex_mode = MODE_HALT;
                end
            end else if (lex_mode != MODE_HALT) begin
                lex_mode = MODE_START;
                dispatch = 1'b1;
            end

            // byte at a token boundary
            if (dispatch) begin
                case (b)
                    CH_LBRACE:   emit_here(KIND_LBRACE);
                    CH_RBRACE:   emit_here(KIND_RBRACE);
                    CH_LBRACKET: emit_here(KIND_LBRACKET);
                    CH_RBRACKET: emit_here(KIND_RBRACKET);
                    CH_COMMA:    emit_here(KIND_COMMA);
                    CH_COLON:    emit_here(KIND_COLON);
                    CH_SPACE, CH_TAB, CH_CR, CH_FF, CH_VT: ;
                    CH_LF:       newline = 1'b1;
                    CH_MINUS: begin
                        mark_start();
                        lex_mode = MODE_NSIGN;
                    end
                    CH_ZERO: begin
                        mark_start();
                        lex_mode = MODE_NZERO;
                    end
                    CH_QUOTE: begin
                        // string content starts after the quote
                        tok_offset = sat_off(doc_offset);
                        tok_line   = cur_line;
                        tok_col    = sat_pos(cur_col);
                        lex_mode   = MODE_STR;
                    end
                    default: begin
                        if (folded == CH_UP_T || folded == CH_UP_F || folded == CH_UP_N) begin
                            mark_start();
                            kw_sel   = (folded == CH_UP_T) ? KW_TRUE :
                                       (folded == CH_UP_F) ? KW_FALSE : KW_NULL;
                            kw_idx   = 3'd1;
                            lex_mode = MODE_KEYW;
                        end else if (digit) begin
                            mark_start();
                            lex_mode = MODE_NINT;
                        end else begin
                            emit(KIND_ERROR, ERR_BAD_CHAR, doc_offset, '0, cur_line, cur_col);
                            lex_mode = MODE_HALT;
                        end
                    end
                endcase
            end

            // position bookkeeping
            doc_offset = sat_off(doc_offset);
            if (newline) begin
                cur_line = sat_pos(cur_line);
                cur_col  = 1;
            end else begin
                cur_col = sat_pos(cur_col);
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_total++;
        end
    endfunction

    initial begin
        clear_lexer();
        mismatch_total = 0;
    end

    // predict on each byte request, compare on each token
    always @(posedge i_clk) begin : track
        t_result tok;
        t_result want;
        if (!i_rst_n) begin
            clear_lexer();
            tokens_due.delete();
        end else begin
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                lex_step(i_byte_ch.text_byte, i_byte_ch.end_of_input);
                for (int k = 0; k < step_n; k++) begin
                    tok             = step_tok[k];
                    tok.last_of_run = (k == step_n - 1);
                    tokens_due.push_back(tok);
                end
            end
            if (i_tok_ch.valid && i_tok_ch.ready) begin
                if (tokens_due.size() == 0) begin
                    $error("token with no request pending: kind %0d offset %0d",
                           i_tok_ch.token_kind, i_tok_ch.token_offset);
                    mismatch_total++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.token_kind, i_tok_ch.token_kind);
                    check_field("error_code", want.error_code, i_tok_ch.error_code);
                    check_field("token_offset", want.token_offset, i_tok_ch.token_offset);
                    check_field("token_length", want.token_length, i_tok_ch.token_length);
                    check_field("line_number", want.line_number, i_tok_ch.line_number);
                    check_field("column_number", want.column_number, i_tok_ch.column_number);
                    check_field("last_of_run", want.last_of_run, i_tok_ch.last_of_run);
                end
            end
        end
        o_expect_count <= tokens_due.size();
        o_fail_count   <= mismatch_total;
    end

endmodule

>>> tb/sv/json_token_lexer_tb.sv
// json_token_lexer_tb: document stimulus, receiver stalls and verdict for the json token lexer
`timescale 1ns / 100ps
module json_token_lexer_tb;
    import jtl_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam logic [7:0] LOWER_BIT      = ~CASE_FOLD;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic sink_ready  = 1'b0;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   stall_left  = 0;
    int   bytes_sent  = 0;
    int   stuck_cycles = 0;
    int   fail_count;
    int   tokens_pending;

    jtl_in_if  in_ch ();
    jtl_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    json_token_lexer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    jtl_token_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_byte_ch      (in_ch),
        .i_tok_ch       (out_ch),
        .o_fail_count   (fail_count),
        .o_expect_count (tokens_pending)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls in bursts of random length
    always @(posedge clk) begin
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(10);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // give up when neither channel moves for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // one byte request, with an optional sender gap before it
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.text_byte    <= b;
        in_ch.end_of_input <= eoi;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], 1'b0);
    endtask

    // hold off until every token owed has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (tokens_pending != 0);
    endtask

    function automatic logic [7:0] random_case(input logic [7:0] ch);
        return $urandom_range(1) ? (ch | LOWER_BIT) : ch;
    endfunction

    function automatic logic [7:0] rand_digit(input int lo);
        return CH_ZERO + $urandom_range(lo, 9);
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(5))
            0:       return CH_LBRACE;
            1:       return CH_RBRACE;
            2:       return CH_LBRACKET;
            3:       return CH_RBRACKET;
            4:       return CH_COMMA;
            default: return CH_COLON;
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(6))
            0:       return CH_TAB;
            1:       return CH_CR;
            2:       return CH_FF;
            3:       return CH_VT;
            4, 5:    return CH_LF;
            default: return CH_SPACE;
        endcase
    endfunction

    // string body byte, never a quote or a backslash
    function automatic logic [7:0] string_char();
        logic [7:0] b;
        do b = $urandom_range(1, 255); while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    task automatic end_document();
        if ($urandom_range(3) == 0) send_byte(CH_NUL, 1'b0);
        else send_byte($urandom_range(255), 1'b1);
    endtask

    task automatic send_int_part();
        if ($urandom_range(3) == 0) send_byte(CH_MINUS, 1'b0);
        if ($urandom_range(2) == 0) begin
            send_byte(CH_ZERO, 1'b0);
        end else begin
            send_byte(rand_digit(1), 1'b0);
            repeat ($urandom_range(3)) send_byte(rand_digit(0), 1'b0);
        end
    endtask

    task automatic send_exp_head();
        send_byte(random_case(CH_UP_E), 1'b0);
        if ($urandom_range(1)) send_byte($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
    endtask

    task automatic send_number();
        send_int_part();
        if ($urandom_range(1)) begin
            send_byte(CH_DOT, 1'b0);
            repeat ($urandom_range(1, 3)) send_byte(rand_digit(0), 1'b0);
        end
        if ($urandom_range(2) == 0) begin
            send_exp_head();
            repeat ($urandom_range(1, 2)) send_byte(rand_digit(0), 1'b0);
        end
    endtask

    task automatic send_string_body();
        repeat ($urandom_range(6)) begin
            if ($urandom_range(5) == 0) begin
                // escape lets any nonzero byte through, a quote too
                send_byte(CH_BACKSLASH, 1'b0);
                send_byte($urandom_range(1, 255), 1'b0);
            end else begin
                send_byte(string_char(), 1'b0);
            end
        end
    endtask

    task automatic send_keyword(input bit partial);
        string word;
        int    count;
        case ($urandom_range(2))
            0:       word = "TRUE";
            1:       word = "FALSE";
            default: word = "NULL";
        endcase
        count = partial ? $urandom_range(1, word.len() - 1) : word.len();
        for (int k = 0; k < count; k++) send_byte(random_case(word[k]), 1'b0);
    endtask

    // unfinished or malformed token, maybe a stray byte, then the end
    task automatic send_broken();
        case ($urandom_range(5))
            0: send_byte(CH_MINUS, 1'b0);
            1: begin
                send_int_part();
                send_byte(CH_DOT, 1'b0);
            end
            2: begin
                send_int_part();
                send_exp_head();
            end
            3: begin
                send_byte(CH_QUOTE, 1'b0);
                send_string_body();
            end
            4: send_keyword(1'b1);
            default: ;
        endcase
        if ($urandom_range(1)) send_byte($urandom_range(1, 255), 1'b0);
        end_document();
    endtask

    // mostly well-formed documents with random content
    task automatic send_document();
        repeat ($urandom_range(2, 12)) begin
            case ($urandom_range(8))
                0, 1: send_byte(pick_punct(), 1'b0);
                2:    send_byte(pick_space(), 1'b0);
                3, 4: send_number();
                5, 6: begin
                    send_byte(CH_QUOTE, 1'b0);
                    send_string_body();
                    send_byte(CH_QUOTE, 1'b0);
                end
                default: send_keyword(1'b0);
            endcase
            // sometimes no delimiter at all between tokens
            case ($urandom_range(3))
                0:       send_byte(pick_punct(), 1'b0);
                1:       send_byte(pick_space(), 1'b0);
                default: ;
            endcase
        end
        if ($urandom_range(4) == 0) send_broken();
        else end_document();
    endtask

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.text_byte    <= '0;
        in_ch.end_of_input <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all punctuators but the closing brace, escaped quote, full number, newline,
        // mixed-case keyword, zero byte as end, lone minus cut by the end marker
        send_text("{\"\\\"\":-0.5E+3,\n[fAlSe]");
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_MINUS, 1'b0);
        send_byte(8'hFF, 1'b1);

        // random documents with light idling on both sides
        gap_pct   = 20;
        stall_pct = 20;
        while (bytes_sent < 400) send_document();

        // a stretch with no idling
        gap_pct   = 0;
        stall_pct = 0;
        while (bytes_sent < 600) send_document();

        wait_drained();

        // slow receiver so the queue fills and ready drops
        gap_pct   = 10;
        stall_pct = 45;
        while (bytes_sent < 880) send_document();

        // final part at full rate
        gap_pct   = 0;
        stall_pct = 0;
        while (bytes_sent < 1075) send_document();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
